// ===== hdl/srca_pkg.sv =====
// ----------------------------------------------------------------------------
// srca_pkg
// Shared types and constants for the spiral route transposition cipher.
// ----------------------------------------------------------------------------
package srca_pkg;

    localparam int MAX_CELLS = 64;
    localparam int ADDR_W    = $clog2(MAX_CELLS);
    localparam int CNT_W     = $clog2(MAX_CELLS + 1);
    localparam int CFG_W     = 7;
    localparam int CFG_IDX_W = 1;

    localparam logic [CFG_IDX_W-1:0] CFG_COLUMN_COUNT  = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_DIRECTION_CCW = 1'd1;

    localparam logic [CFG_W-1:0] COLS_RESET = 7'd8;

    localparam logic [7:0] CHAR_UP_A  = 8'd65;
    localparam logic [7:0] CHAR_UP_Z  = 8'd90;
    localparam logic [7:0] CHAR_LO_A  = 8'd97;
    localparam logic [7:0] CHAR_LO_Z  = 8'd122;
    localparam logic [7:0] CASE_SHIFT = 8'd32;
    localparam logic [6:0] PAD_LETTER = 7'h58;

    typedef struct packed {
        logic [7:0] char_code;
        logic       last_char;
    } t_in_item;

    typedef struct packed {
        logic [6:0] letter;
        logic       end_of_run;
        logic       empty_message;
        logic       overflowed;
    } t_out_item;

    typedef enum logic [1:0] {
        ST_LOAD,
        ST_SIZE,
        ST_WALK,
        ST_EMPTY
    } t_state;

    typedef enum logic [1:0] {
        DIR_DN,
        DIR_LF,
        DIR_UP,
        DIR_RT
    } t_dir;

endpackage

// ===== hdl/srca_ram.sv =====
// ----------------------------------------------------------------------------
// srca_ram
// Generic simple dual-port RAM: one write port, one read port with a read
// enable and a registered read data output.
// ----------------------------------------------------------------------------
module srca_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ===== hdl/spiral_route_cipher.sv =====
// ----------------------------------------------------------------------------
// spiral_route_cipher
// Spiral route transposition cipher over a letter grid held in a RAM.
// ----------------------------------------------------------------------------
// Message bytes are taken one per cycle; letters are upper-cased and written
// to a 64-entry letter RAM, other bytes are dropped. The transfer marked
// last_char starts emission: a sizing pass adds the column count once per
// grid row, then the spiral walker reads the RAM one cell per cycle and
// delivers one letter per cycle while the output side keeps up, padding the
// last row with X. No input is taken during sizing and walking; loading of
// the next message resumes as the last cell is read.
// An empty message yields a single result flagged empty.
// ----------------------------------------------------------------------------
module spiral_route_cipher
    import srca_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_valid,
    output logic                 o_ready,
    input  t_in_item             i_data,
    output logic                 o_valid,
    input  logic                 i_ready,
    output t_out_item            o_data,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [CFG_W-1:0]     i_cfg_wdata
);

    localparam logic [CNT_W-1:0] MAX_CNT = CNT_W'(MAX_CELLS);

    // configuration
    logic [CFG_W-1:0] r_cfg_cols;
    logic             r_cfg_ccw;

    // control
    t_state           r_state, n_state;
    logic [CNT_W-1:0] r_count, n_count;
    logic             r_ovf_seen, n_ovf_seen;

    // sizing / run
    logic [CNT_W-1:0] r_cols, n_cols;
    logic [CNT_W-1:0] r_acc, n_acc;
    logic [CNT_W-1:0] r_rows, n_rows;
    logic [CNT_W-1:0] r_neff, n_neff;
    logic             r_run_ovf, n_run_ovf;
    logic             r_ccw, n_ccw;

    // walker
    logic [ADDR_W-1:0] r_x, n_x, r_y, n_y;
    logic [ADDR_W-1:0] r_left, n_left, r_right, n_right;
    logic [ADDR_W-1:0] r_top, n_top, r_bottom, n_bottom;
    logic [ADDR_W-1:0] r_idx, n_idx;
    t_dir              r_dir, n_dir;
    logic [CNT_W-1:0]  r_k, n_k;

    // read stage and output register
    logic        r_p1_vld, r_p1_pad, r_p1_last, r_p1_ovf;
    logic        r_out_vld;
    t_out_item   r_out;

    logic [7:0]       ram_rdata;
    logic             ram_we, ram_re;
    logic [7:0]       up_char;
    logic             is_letter;
    logic             in_xfer;
    logic             move, issue, empty_load, walk_last;
    logic [CNT_W-1:0] eff_cols;
    logic [CNT_W:0]   acc_sum;
    logic             blocked;
    t_dir             turn_dir;

    assign in_xfer   = i_valid && o_ready;
    assign o_ready   = (r_state == ST_LOAD);
    assign move      = !r_out_vld || i_ready;
    assign issue     = (r_state == ST_WALK) && (!r_p1_vld || move);
    assign empty_load = (r_state == ST_EMPTY) && !r_p1_vld && move;
    assign walk_last = (r_k + CNT_W'(1)) == r_acc;

    always_comb begin
        is_letter = 1'b0;
        up_char   = i_data.char_code;
        if (i_data.char_code >= CHAR_UP_A && i_data.char_code <= CHAR_UP_Z) begin
            is_letter = 1'b1;
        end else if (i_data.char_code >= CHAR_LO_A && i_data.char_code <= CHAR_LO_Z) begin
            is_letter = 1'b1;
            up_char   = i_data.char_code - CASE_SHIFT;
        end
    end

    assign ram_we = in_xfer && is_letter && (r_count < MAX_CNT);
    assign ram_re = issue;

    srca_ram #(
        .WIDTH (8),
        .DEPTH (MAX_CELLS)
    ) u_letter_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (r_count[ADDR_W-1:0]),
        .i_wdata (up_char),
        .i_re    (ram_re),
        .i_raddr (r_idx),
        .o_rdata (ram_rdata)
    );

    always_comb begin
        if (r_cfg_cols == '0) begin
            eff_cols = CNT_W'(1);
        end else if (CNT_W'(r_cfg_cols) > MAX_CNT) begin
            eff_cols = MAX_CNT;
        end else begin
            eff_cols = CNT_W'(r_cfg_cols);
        end
    end

    assign acc_sum = {1'b0, r_acc} + {1'b0, r_cols};

    // walker: blocked test, turn
    always_comb begin
        case (r_dir)
            DIR_DN:  blocked = (r_y == r_bottom);
            DIR_LF:  blocked = (r_x == r_left);
            DIR_UP:  blocked = (r_y == r_top);
            DIR_RT:  blocked = (r_x == r_right);
            default: blocked = 1'b0;
        endcase
        case (r_dir)
            DIR_DN:  turn_dir = r_ccw ? DIR_RT : DIR_LF;
            DIR_LF:  turn_dir = r_ccw ? DIR_DN : DIR_UP;
            DIR_UP:  turn_dir = r_ccw ? DIR_LF : DIR_RT;
            DIR_RT:  turn_dir = r_ccw ? DIR_UP : DIR_DN;
            default: turn_dir = DIR_DN;
        endcase
    end

    always_comb begin
        n_state    = r_state;
        n_count    = r_count;
        n_ovf_seen = r_ovf_seen;
        n_cols     = r_cols;
        n_acc      = r_acc;
        n_rows     = r_rows;
        n_neff     = r_neff;
        n_run_ovf  = r_run_ovf;
        n_ccw      = r_ccw;
        n_x        = r_x;
        n_y        = r_y;
        n_left     = r_left;
        n_right    = r_right;
        n_top      = r_top;
        n_bottom   = r_bottom;
        n_idx      = r_idx;
        n_dir      = r_dir;
        n_k        = r_k;

        case (r_state)
            ST_LOAD: begin
                if (in_xfer) begin
                    if (ram_we) begin
                        n_count = r_count + CNT_W'(1);
                    end else if (is_letter) begin
                        n_ovf_seen = 1'b1;
                    end
                    if (i_data.last_char) begin
                        if (n_count == '0) begin
                            n_state    = ST_EMPTY;
                            n_ovf_seen = 1'b0;
                        end else begin
                            n_state = ST_SIZE;
                            n_cols  = eff_cols;
                            n_ccw   = r_cfg_ccw;
                            n_acc   = '0;
                            n_rows  = '0;
                        end
                    end
                end
            end
            ST_SIZE: begin
                if (r_acc < r_count && acc_sum <= (CNT_W+1)'(MAX_CELLS)) begin
                    n_acc  = acc_sum[CNT_W-1:0];
                    n_rows = r_rows + CNT_W'(1);
                end else begin
                    n_state    = ST_WALK;
                    n_neff     = (r_count > r_acc) ? r_acc : r_count;
                    n_run_ovf  = r_ovf_seen || (r_count > r_acc);
                    n_count    = '0;
                    n_ovf_seen = 1'b0;
                    n_x        = ADDR_W'(r_cols - CNT_W'(1));
                    n_y        = '0;
                    n_left     = '0;
                    n_right    = ADDR_W'(r_cols - CNT_W'(1));
                    n_top      = '0;
                    n_bottom   = ADDR_W'(r_rows - CNT_W'(1));
                    n_idx      = ADDR_W'(r_cols - CNT_W'(1));
                    n_dir      = r_ccw ? DIR_LF : DIR_DN;
                    n_k        = '0;
                end
            end
            ST_WALK: begin
                if (issue) begin
                    n_k = r_k + CNT_W'(1);
                    if (walk_last) begin
                        n_state = ST_LOAD;
                    end
                    if (blocked) begin
                        n_dir = turn_dir;
                        case (r_dir)
                            DIR_DN: begin
                                if (r_ccw) n_left = r_left + ADDR_W'(1);
                                else       n_right = r_right - ADDR_W'(1);
                            end
                            DIR_LF: begin
                                if (r_ccw) n_top = r_top + ADDR_W'(1);
                                else       n_bottom = r_bottom - ADDR_W'(1);
                            end
                            DIR_UP: begin
                                if (r_ccw) n_right = r_right - ADDR_W'(1);
                                else       n_left = r_left + ADDR_W'(1);
                            end
                            DIR_RT: begin
                                if (r_ccw) n_bottom = r_bottom - ADDR_W'(1);
                                else       n_top = r_top + ADDR_W'(1);
                            end
                            default: begin
                                n_dir = r_dir;
                            end
                        endcase
                    end
                    case (n_dir)
                        DIR_DN: begin
                            n_y   = r_y + ADDR_W'(1);
                            n_idx = r_idx + ADDR_W'(r_cols);
                        end
                        DIR_LF: begin
                            n_x   = r_x - ADDR_W'(1);
                            n_idx = r_idx - ADDR_W'(1);
                        end
                        DIR_UP: begin
                            n_y   = r_y - ADDR_W'(1);
                            n_idx = r_idx - ADDR_W'(r_cols);
                        end
                        DIR_RT: begin
                            n_x   = r_x + ADDR_W'(1);
                            n_idx = r_idx + ADDR_W'(1);
                        end
                        default: begin
                            n_idx = r_idx;
                        end
                    endcase
                end
            end
            ST_EMPTY: begin
                if (empty_load) begin
                    n_state = ST_LOAD;
                end
            end
            default: begin
                n_state = ST_LOAD;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= ST_LOAD;
            r_count    <= '0;
            r_ovf_seen <= 1'b0;
            r_cfg_cols <= COLS_RESET;
            r_cfg_ccw  <= 1'b0;
            r_p1_vld   <= 1'b0;
            r_out_vld  <= 1'b0;
        end else begin
            r_state    <= n_state;
            r_count    <= n_count;
            r_ovf_seen <= n_ovf_seen;
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    CFG_COLUMN_COUNT:  r_cfg_cols <= i_cfg_wdata;
                    CFG_DIRECTION_CCW: r_cfg_ccw  <= i_cfg_wdata[0];
                    default: ;
                endcase
            end
            if (issue) begin
                r_p1_vld <= 1'b1;
            end else if (move) begin
                r_p1_vld <= 1'b0;
            end
            if ((r_p1_vld && move) || empty_load) begin
                r_out_vld <= 1'b1;
            end else if (i_ready) begin
                r_out_vld <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_cols    <= n_cols;
        r_acc     <= n_acc;
        r_rows    <= n_rows;
        r_neff    <= n_neff;
        r_run_ovf <= n_run_ovf;
        r_ccw     <= n_ccw;
        r_x       <= n_x;
        r_y       <= n_y;
        r_left    <= n_left;
        r_right   <= n_right;
        r_top     <= n_top;
        r_bottom  <= n_bottom;
        r_idx     <= n_idx;
        r_dir     <= n_dir;
        r_k       <= n_k;
        if (issue) begin
            r_p1_pad  <= CNT_W'(r_idx) >= r_neff;
            r_p1_last <= walk_last;
            r_p1_ovf  <= r_run_ovf;
        end
        if (r_p1_vld && move) begin
            r_out.letter        <= r_p1_pad ? PAD_LETTER : ram_rdata[6:0];
            r_out.end_of_run    <= r_p1_last;
            r_out.empty_message <= 1'b0;
            r_out.overflowed    <= r_p1_ovf;
        end else if (empty_load) begin
            r_out.letter        <= '0;
            r_out.end_of_run    <= 1'b1;
            r_out.empty_message <= 1'b1;
            r_out.overflowed    <= 1'b0;
        end
    end

    assign o_valid = r_out_vld;
    assign o_data  = r_out;

endmodule

// ===== tb/tb_top.sv =====
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the spiral route transposition cipher.
// ----------------------------------------------------------------------------
// A driver streams message bytes from a queue. Each accepted byte updates a
// letter grid kept in the bench; a byte marked last expands that grid into
// the expected spiral letters. A monitor compares every delivered letter
// with the oldest expected one. Both sides insert random gaps, and at one
// point the output side holds off long enough to stall the input. The grid
// width and spiral direction are changed between phases, while the block is
// idle, and cover the extreme widths and both directions.
// ----------------------------------------------------------------------------
module tb_top
    import srca_pkg::*;
();

    localparam int SETTLE   = 100;
    localparam int HOLD_LEN = 150;
    localparam int WD_LIMIT = 5000;

    logic                 i_clk       = 1'b0;
    logic                 i_rst_n     = 1'b0;
    logic                 i_valid     = 1'b0;
    logic                 o_ready;
    t_in_item             i_data      = '0;
    logic                 o_valid;
    logic                 i_ready     = 1'b0;
    t_out_item            o_data;
    logic                 i_cfg_we    = 1'b0;
    logic [CFG_IDX_W-1:0] i_cfg_idx   = CFG_COLUMN_COUNT;
    logic [CFG_W-1:0]     i_cfg_wdata = '0;

    t_in_item   msg_q[$];
    t_out_item  cipher_q[$];
    t_out_item  want_item;

    logic [7:0]       grid_mem[MAX_CELLS];
    int               held_cnt  = 0;
    logic             held_ovf  = 1'b0;
    logic [CFG_W-1:0] cols_cfg  = COLS_RESET;
    logic             ccw_cfg   = 1'b0;

    int   err_cnt   = 0;
    int   tx_gap    = 0;
    int   rx_wait   = 0;
    int   stall_cnt = 0;
    logic quiet_tx  = 1'b0;
    logic quiet_rx  = 1'b0;
    logic hold_req  = 1'b0;
    logic hold_done = 1'b0;

    spiral_route_cipher DUT (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .o_ready     (o_ready),
        .i_data      (i_data),
        .o_valid     (o_valid),
        .i_ready     (i_ready),
        .o_data      (o_data),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_wdata (i_cfg_wdata)
    );

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    function automatic int gap_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 70) begin
            return $urandom_range(1, 2);
        end else if (r < 92) begin
            return $urandom_range(3, 6);
        end
        return $urandom_range(12, 40);
    endfunction

    // expand the held grid into spiral order
    function automatic void emit_spiral();
        int        cols, cap, n, rows, total, x, y, dx, dy, odx, nx, ny, idx;
        logic [63:0] seen;
        logic      ovf, blk;
        t_out_item o;
        cols = (cols_cfg == 0) ? 1 : ((cols_cfg > MAX_CELLS) ? MAX_CELLS : int'(cols_cfg));
        cap  = (MAX_CELLS / cols) * cols;
        n    = held_cnt;
        ovf  = held_ovf;
        if (n > cap) begin
            n   = cap;
            ovf = 1'b1;
        end
        rows  = (n + cols - 1) / cols;
        total = rows * cols;
        seen  = '0;
        x     = cols - 1;
        y     = 0;
        dx    = ccw_cfg ? -1 : 0;
        dy    = ccw_cfg ? 0 : 1;
        for (int k = 0; k < total; k++) begin
            o.letter = PAD_LETTER;
            if (x >= 0 && y >= 0 && x < cols && y < rows) begin
                idx = y * cols + x;
                if (idx < n) begin
                    o.letter = grid_mem[idx][6:0];
                end
                seen[idx] = 1'b1;
            end
            o.end_of_run    = (k == total - 1);
            o.empty_message = 1'b0;
            o.overflowed    = ovf;
            cipher_q.insert(cipher_q.size(), o);
            nx  = x + dx;
            ny  = y + dy;
            blk = (nx < 0 || ny < 0 || nx >= cols || ny >= rows);
            if (!blk && seen[ny * cols + nx]) begin
                blk = 1'b1;
            end
            if (blk) begin
                odx = dx;
                if (!ccw_cfg) begin
                    dx = -dy;
                    dy = odx;
                end else begin
                    dx = dy;
                    dy = -odx;
                end
            end
            x = x + dx;
            y = y + dy;
        end
        held_cnt = 0;
        held_ovf = 1'b0;
    endfunction

    function automatic void take_char(t_in_item it);
        logic [7:0] up;
        logic       is_let;
        t_out_item  o;
        is_let = 1'b0;
        up     = it.char_code;
        if (it.char_code >= CHAR_UP_A && it.char_code <= CHAR_UP_Z) begin
            is_let = 1'b1;
        end else if (it.char_code >= CHAR_LO_A && it.char_code <= CHAR_LO_Z) begin
            is_let = 1'b1;
            up     = it.char_code - CASE_SHIFT;
        end
        if (is_let) begin
            if (held_cnt < MAX_CELLS) begin
                grid_mem[held_cnt] = up;
                held_cnt++;
            end else begin
                held_ovf = 1'b1;
            end
        end
        if (it.last_char) begin
            if (held_cnt == 0) begin
                o.letter        = '0;
                o.end_of_run    = 1'b1;
                o.empty_message = 1'b1;
                o.overflowed    = 1'b0;
                cipher_q.insert(cipher_q.size(), o);
                held_ovf = 1'b0;
            end else begin
                emit_spiral();
            end
        end
    endfunction

    // driver
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_valid <= 1'b0;
        end else begin
            if (i_valid && o_ready) begin
                take_char(i_data);
            end
            if (!i_valid || o_ready) begin
                if (tx_gap > 0) begin
                    tx_gap--;
                    i_valid <= 1'b0;
                end else if (msg_q.size() != 0) begin
                    i_valid <= 1'b1;
                    i_data  <= msg_q.pop_front();
                    if (!quiet_tx && $urandom_range(0, 99) < 35) begin
                        tx_gap = gap_len();
                    end
                end else begin
                    i_valid <= 1'b0;
                end
            end
        end
    end

    // monitor
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_ready <= 1'b0;
        end else begin
            if (o_valid && i_ready) begin
                if (cipher_q.size() == 0) begin
                    err_cnt++;
                    $display("%0t: unexpected transfer: letter %h end %b empty %b ovf %b",
                             $time, o_data.letter, o_data.end_of_run,
                             o_data.empty_message, o_data.overflowed);
                end else begin
                    want_item = cipher_q.pop_front();
                    if (o_data !== want_item) begin
                        err_cnt++;
                        $display("%0t: mismatch: expected %h/%b/%b/%b, got %h/%b/%b/%b",
                                 $time, want_item.letter, want_item.end_of_run,
                                 want_item.empty_message, want_item.overflowed,
                                 o_data.letter, o_data.end_of_run,
                                 o_data.empty_message, o_data.overflowed);
                    end
                end
            end
            if (hold_req && !hold_done) begin
                hold_done = 1'b1;
                rx_wait   = HOLD_LEN;
            end
            if (rx_wait > 0) begin
                rx_wait--;
                i_ready <= 1'b0;
            end else begin
                i_ready <= 1'b1;
                if (!quiet_rx && $urandom_range(0, 99) < 20) begin
                    rx_wait = gap_len();
                end
            end
        end
    end

    // watchdog
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if ((i_valid && o_ready) || (o_valid && i_ready) ||
                (msg_q.size() == 0 && !i_valid && cipher_q.size() == 0)) begin
                stall_cnt = 0;
            end else begin
                stall_cnt++;
            end
            if (stall_cnt >= WD_LIMIT) begin
                $display("%0t: no transfer for %0d cycles", $time, WD_LIMIT);
                $display("spiral_route_cipher test failed");
                $finish;
            end
        end
    end

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] val);
        @(posedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_idx   <= idx;
        i_cfg_wdata <= val;
        if (idx == CFG_COLUMN_COUNT) begin
            cols_cfg = val;
        end else begin
            ccw_cfg = val[0];
        end
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    task automatic set_cfg(input logic [CFG_W-1:0] cols, input logic [CFG_W-1:0] dir_word);
        write_reg(CFG_COLUMN_COUNT, cols);
        write_reg(CFG_DIRECTION_CCW, dir_word);
    endtask

    function automatic void push_byte(input logic [7:0] c, input logic last);
        t_in_item it;
        it.char_code = c;
        it.last_char = last;
        msg_q.insert(msg_q.size(), it);
    endfunction

    function automatic void push_text(input string s);
        for (int i = 0; i < s.len(); i++) begin
            push_byte(s[i], i == s.len() - 1);
        end
    endfunction

    function automatic logic [7:0] rand_char();
        int r;
        r = $urandom_range(0, 99);
        if (r < 40) begin
            return CHAR_UP_A + 8'($urandom_range(0, 25));
        end else if (r < 75) begin
            return CHAR_LO_A + 8'($urandom_range(0, 25));
        end
        return 8'($urandom_range(0, 255));
    endfunction

    function automatic void rand_msg(input int nletters, input int max_len);
        int len;
        len = (nletters > 0) ? nletters : $urandom_range(1, max_len);
        for (int i = 0; i < len; i++) begin
            if (nletters > 0) begin
                push_byte(CHAR_UP_A + 8'($urandom_range(0, 25)) +
                          ($urandom_range(0, 1) ? CASE_SHIFT : 8'd0), 1'b0);
            end else begin
                push_byte(rand_char(), i == len - 1);
            end
        end
    endfunction

    task automatic drain();
        while (msg_q.size() != 0 || i_valid || cipher_q.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (SETTLE) @(posedge i_clk);
    endtask

    initial begin
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed: letter boundaries, non-letters, empty messages, one letter
        set_cfg(7'd3, 7'd0);
        push_byte(8'h00, 1'b0);
        push_byte(CHAR_UP_A, 1'b0);
        push_byte(8'h40, 1'b0);
        push_byte(CHAR_UP_Z, 1'b0);
        push_byte(8'h5B, 1'b0);
        push_byte(8'h60, 1'b0);
        push_byte(CHAR_LO_A, 1'b0);
        push_byte(CHAR_LO_Z, 1'b0);
        push_byte(8'h7B, 1'b0);
        push_byte(8'hFF, 1'b1);
        push_byte(8'h35, 1'b0);
        push_byte(8'h20, 1'b1);
        push_byte(8'h80, 1'b1);
        push_byte(CHAR_LO_A + 8'd16, 1'b1);
        drain();

        set_cfg(7'd4, 7'd1);
        push_text("SpiralRun");
        drain();

        // store overflow and grid too large: 65 letters into 33 columns
        set_cfg(7'd33, 7'd1);
        rand_msg(65, 0);
        push_byte(8'h2E, 1'b1);
        drain();

        for (int ph = 0; ph < 4; ph++) begin
            case (ph)
                0: begin
                    set_cfg(7'd0, 7'd1);
                end
                1: begin
                    set_cfg(7'd127, 7'd0);
                end
                default: begin
                    set_cfg(7'($urandom_range(1, 10)), 7'($urandom_range(0, 127)));
                end
            endcase
            hold_req <= (ph == 2);
            quiet_tx <= (ph == 3);
            quiet_rx <= (ph == 3);
            repeat (2) rand_msg(0, 6);
            drain();
        end

        if (err_cnt == 0 && cipher_q.size() == 0) begin
            $display("spiral_route_cipher test passed");
        end else begin
            $display("spiral_route_cipher test failed");
        end
        $finish;
    end

endmodule
